/* hdl/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types, register indexes and constants for the bank mapper block.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int ROM_ADDR_BITS_DEF = 23;
    localparam int RAM_ADDR_BITS_DEF = 17;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int PHYS_W   = 23;
    localparam int LOG2_W   = 5;
    localparam int ROMBNK_W = 9;
    localparam int RAMBNK_W = 8;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [LOG2_W-1:0] ROM_MIN_LOG2   = 5'd15;
    localparam logic [LOG2_W-1:0] RAM_MIN_LOG2   = 5'd9;
    localparam logic [LOG2_W-1:0] ROM_RESET_LOG2 = 5'd15;
    localparam logic [LOG2_W-1:0] RAM_RESET_LOG2 = 5'd13;

    // Low nibble that unlocks external RAM.
    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    localparam logic [ROMBNK_W-1:0] ROM_PAGE_RESET = 9'd1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MAPPER_KIND = 2'd0;
    localparam logic [1:0] REG_ROM_LOG2    = 2'd1;
    localparam logic [1:0] REG_RAM_LOG2    = 2'd2;
    localparam logic [1:0] REG_RAM_PRESENT = 2'd3;

    // Register write windows below 0x8000, selected by address bits 14:13.
    localparam logic [1:0] WIN_RAM_EN   = 2'b00;
    localparam logic [1:0] WIN_ROM_PAGE = 2'b01;
    localparam logic [1:0] WIN_RAM_PAGE = 2'b10;
    localparam logic [1:0] WIN_MODE     = 2'b11;

    // Address bits 15:13 of the external RAM window 0xA000-0xBFFF.
    localparam logic [2:0] RAM_WINDOW = 3'b101;

    typedef enum logic [1:0] {
        KIND_ROM_ONLY = 2'd0,
        KIND_MBC1     = 2'd1,
        KIND_MBC3     = 2'd2,
        KIND_MBC5     = 2'd3
    } mapper_kind_t;

    typedef enum logic [1:0] {
        TGT_NONE      = 2'd0,
        TGT_ROM_READ  = 2'd1,
        TGT_RAM_READ  = 2'd2,
        TGT_RAM_WRITE = 2'd3
    } target_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] bus_addr;
        logic [DATA_W-1:0] wdata;
    } req_t;

    typedef struct packed {
        target_t           target;
        logic [PHYS_W-1:0] phys_addr;
        logic [DATA_W-1:0] ram_wdata;
    } rsp_t;

    typedef struct packed {
        mapper_kind_t      kind;
        logic [LOG2_W-1:0] rom_log2;
        logic [LOG2_W-1:0] ram_log2;
        logic              ram_present;
    } cfg_t;

    typedef struct packed {
        logic [ROMBNK_W-1:0] rom_page;
        logic [RAMBNK_W-1:0] ram_page;
        logic                ram_enabled;
        logic                banking_mode;
    } bank_state_t;

endpackage

/* hdl/cbm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Cartridge bank mapper configuration registers
// APB-style register file holding the mapper kind and memory sizes.
// ----------------------------------------------------------------------------
module cbm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output cbm_pkg::cfg_t                    cfg
);

    cbm_pkg::cfg_t cfg_reg;
    logic [1:0]    index;
    logic          wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind        <= cbm_pkg::KIND_ROM_ONLY;
            cfg_reg.rom_log2    <= cbm_pkg::ROM_RESET_LOG2;
            cfg_reg.ram_log2    <= cbm_pkg::RAM_RESET_LOG2;
            cfg_reg.ram_present <= 1'b0;
        end
        else if (wr_en)
        begin
            case (index)
                cbm_pkg::REG_MAPPER_KIND:
                    cfg_reg.kind <= cbm_pkg::mapper_kind_t'(pwdata[1:0]);
                cbm_pkg::REG_ROM_LOG2:
                    cfg_reg.rom_log2 <= pwdata[cbm_pkg::LOG2_W-1:0];
                cbm_pkg::REG_RAM_LOG2:
                    cfg_reg.ram_log2 <= pwdata[cbm_pkg::LOG2_W-1:0];
                cbm_pkg::REG_RAM_PRESENT:
                    cfg_reg.ram_present <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            cbm_pkg::REG_MAPPER_KIND: prdata = 32'(cfg_reg.kind);
            cbm_pkg::REG_ROM_LOG2:    prdata = 32'(cfg_reg.rom_log2);
            cbm_pkg::REG_RAM_LOG2:    prdata = 32'(cfg_reg.ram_log2);
            cbm_pkg::REG_RAM_PRESENT: prdata = 32'(cfg_reg.ram_present);
            default:                  prdata = '0;
        endcase
    end

endmodule

/* hdl/cbm_bank_regs.sv */
// ----------------------------------------------------------------------------
// Cartridge bank mapper bank registers
// Decodes CPU writes below 0x8000 into ROM bank, RAM bank, enable and mode.
// ----------------------------------------------------------------------------
module cbm_bank_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  cbm_pkg::req_t        req,
    input  cbm_pkg::cfg_t        cfg,
    output cbm_pkg::bank_state_t bank
);

    cbm_pkg::bank_state_t bank_reg;
    cbm_pkg::bank_state_t bank_next;
    logic [1:0]           win;
    logic                 reg_wr;

    assign win    = req.bus_addr[14:13];
    assign reg_wr = fire && (req.op == cbm_pkg::OP_WRITE) && !req.bus_addr[15]
                    && (cfg.kind != cbm_pkg::KIND_ROM_ONLY);
    assign bank   = bank_reg;

    always_comb
    begin
        bank_next = bank_reg;
        if (reg_wr)
        begin
            if (win == cbm_pkg::WIN_RAM_EN)
            begin
                bank_next.ram_enabled = (req.wdata[3:0] == cbm_pkg::RAM_EN_KEY);
            end
            else
            begin
                case (cfg.kind)
                    cbm_pkg::KIND_MBC1:
                    begin
                        case (win)
                            cbm_pkg::WIN_ROM_PAGE:
                                // Bank zero in the low register selects bank one.
                                bank_next.rom_page = (req.wdata[4:0] == 5'd0) ?
                                    cbm_pkg::ROM_PAGE_RESET : {4'd0, req.wdata[4:0]};
                            cbm_pkg::WIN_RAM_PAGE:
                                bank_next.ram_page = {6'd0, req.wdata[1:0]};
                            default:
                                bank_next.banking_mode = req.wdata[0];
                        endcase
                    end
                    cbm_pkg::KIND_MBC3:
                    begin
                        if (win == cbm_pkg::WIN_ROM_PAGE)
                            bank_next.rom_page = {2'd0, req.wdata[6:0]};
                        else if (win == cbm_pkg::WIN_RAM_PAGE)
                            bank_next.ram_page = req.wdata;
                    end
                    cbm_pkg::KIND_MBC5:
                    begin
                        if (win == cbm_pkg::WIN_ROM_PAGE)
                        begin
                            if (!req.bus_addr[12])
                                bank_next.rom_page[7:0] = req.wdata;
                            else
                                bank_next.rom_page[8] = req.wdata[0];
                        end
                        else if (win == cbm_pkg::WIN_RAM_PAGE)
                        begin
                            bank_next.ram_page = {4'd0, req.wdata[3:0]};
                        end
                    end
                    default:
                        bank_next = bank_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.rom_page     <= cbm_pkg::ROM_PAGE_RESET;
            bank_reg.ram_page     <= '0;
            bank_reg.ram_enabled  <= 1'b0;
            bank_reg.banking_mode <= 1'b0;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

endmodule

/* hdl/cbm_translate.sv */
// ----------------------------------------------------------------------------
// Cartridge bank mapper address translation
// Maps one CPU access to its target and wrapped physical ROM or RAM offset.
// ----------------------------------------------------------------------------
module cbm_translate #(
    parameter int ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
    parameter int RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
    input  cbm_pkg::req_t        req,
    input  cbm_pkg::cfg_t        cfg,
    input  cbm_pkg::bank_state_t bank,
    output cbm_pkg::rsp_t        rsp
);

    localparam logic [cbm_pkg::LOG2_W-1:0] ROM_MAX_LOG2 = cbm_pkg::LOG2_W'(ROM_ADDR_BITS);
    localparam logic [cbm_pkg::LOG2_W-1:0] RAM_MAX_LOG2 = cbm_pkg::LOG2_W'(RAM_ADDR_BITS);

    logic [cbm_pkg::LOG2_W-1:0]   rom_bits;
    logic [cbm_pkg::LOG2_W-1:0]   ram_bits;
    logic [ROM_ADDR_BITS-1:0]     rom_mask;
    logic [RAM_ADDR_BITS-1:0]     ram_mask;
    logic [cbm_pkg::ROMBNK_W-1:0] rom_page_nz;
    logic [cbm_pkg::ROMBNK_W-1:0] rom_sel;
    logic [cbm_pkg::RAMBNK_W-1:0] ram_sel;
    logic [cbm_pkg::PHYS_W-1:0]   rom_full;
    logic [20:0]                  ram_full;
    logic [ROM_ADDR_BITS-1:0]     rom_off;
    logic [RAM_ADDR_BITS-1:0]     ram_off;
    logic                         ram_ok;
    logic                         in_ram_window;

    always_comb
    begin
        if (cfg.rom_log2 < cbm_pkg::ROM_MIN_LOG2)
            rom_bits = cbm_pkg::ROM_MIN_LOG2;
        else if (cfg.rom_log2 > ROM_MAX_LOG2)
            rom_bits = ROM_MAX_LOG2;
        else
            rom_bits = cfg.rom_log2;

        if (cfg.ram_log2 < cbm_pkg::RAM_MIN_LOG2)
            ram_bits = cbm_pkg::RAM_MIN_LOG2;
        else if (cfg.ram_log2 > RAM_MAX_LOG2)
            ram_bits = RAM_MAX_LOG2;
        else
            ram_bits = cfg.ram_log2;
    end

    assign rom_mask = {ROM_ADDR_BITS{1'b1}} >> (ROM_MAX_LOG2 - rom_bits);
    assign ram_mask = {RAM_ADDR_BITS{1'b1}} >> (RAM_MAX_LOG2 - ram_bits);

    assign rom_page_nz = (bank.rom_page == '0) ? cbm_pkg::ROM_PAGE_RESET : bank.rom_page;

    always_comb
    begin
        // Only the low nine bank bits can reach the widest ROM offset.
        case (cfg.kind)
            cbm_pkg::KIND_MBC1:
                rom_sel = bank.banking_mode ? rom_page_nz
                                            : (rom_page_nz | {bank.ram_page[3:0], 5'd0});
            cbm_pkg::KIND_MBC3:
                rom_sel = rom_page_nz;
            default:
                rom_sel = bank.rom_page;
        endcase

        case (cfg.kind)
            cbm_pkg::KIND_MBC1:
                ram_sel = bank.banking_mode ? bank.ram_page : '0;
            cbm_pkg::KIND_ROM_ONLY:
                ram_sel = '0;
            default:
                ram_sel = bank.ram_page;
        endcase
    end

    always_comb
    begin
        if ((cfg.kind != cbm_pkg::KIND_ROM_ONLY) && req.bus_addr[14])
            rom_full = {rom_sel, req.bus_addr[13:0]};
        else
            rom_full = {7'd0, req.bus_addr};
    end

    assign ram_full = {ram_sel, req.bus_addr[12:0]};
    assign rom_off  = rom_full[ROM_ADDR_BITS-1:0] & rom_mask;
    assign ram_off  = ram_full[RAM_ADDR_BITS-1:0] & ram_mask;

    assign in_ram_window = (req.bus_addr[15:13] == cbm_pkg::RAM_WINDOW);
    // The MBC3 bank numbers above three select clock registers, which are absent.
    assign ram_ok = cfg.ram_present && bank.ram_enabled
                    && !((cfg.kind == cbm_pkg::KIND_MBC3) && (bank.ram_page > 8'd3));

    always_comb
    begin
        rsp.target    = cbm_pkg::TGT_NONE;
        rsp.phys_addr = '0;
        rsp.ram_wdata = '0;
        if (!req.bus_addr[15])
        begin
            if (req.op == cbm_pkg::OP_READ)
            begin
                rsp.target    = cbm_pkg::TGT_ROM_READ;
                rsp.phys_addr = cbm_pkg::PHYS_W'(rom_off);
            end
        end
        else if (in_ram_window && ram_ok)
        begin
            rsp.phys_addr = cbm_pkg::PHYS_W'(ram_off);
            if (req.op == cbm_pkg::OP_WRITE)
            begin
                rsp.target    = cbm_pkg::TGT_RAM_WRITE;
                rsp.ram_wdata = req.wdata;
            end
            else
            begin
                rsp.target = cbm_pkg::TGT_RAM_READ;
            end
        end
    end

endmodule

/* hdl/cartridge_bank_mapper_core.sv */
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// A request accepted into the input register is translated combinationally;
// its result is captured in the result register. Throughput: one request per
// cycle while results are taken, set by the single translation stage.
// Bank registers update as a request leaves the input register, so the next one
// sees them. Reset clears the pipeline valids and returns the configuration and
// bank registers to their power-on values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core #(
    parameter int ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
    parameter int RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  cbm_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output cbm_pkg::rsp_t                  rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cbm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    cbm_pkg::cfg_t        cfg;
    cbm_pkg::bank_state_t bank;
    cbm_pkg::req_t        s1_req_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    cbm_pkg::rsp_t        rsp_reg;
    cbm_pkg::rsp_t        rsp_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 advance;
    logic                 s1_fire;

    cbm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbm_bank_regs u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .req   (s1_req_reg),
        .cfg   (cfg),
        .bank  (bank)
    );

    cbm_translate #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_xlate (
        .req  (s1_req_reg),
        .cfg  (cfg),
        .bank (bank),
        .rsp  (rsp_next)
    );

    // The result register moves whenever it is empty or being drained.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign req_ready = !s1_valid_reg || advance;

    assign s1_valid_next  = (req_valid && req_ready) ? 1'b1 : (s1_valid_reg && !advance);
    assign rsp_valid_next = advance ? s1_valid_reg : rsp_valid_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_req_reg <= req;
        if (s1_fire)
            rsp_reg <= rsp_next;
    end

endmodule

/* verif/bank_map_checker.sv */
// ----------------------------------------------------------------------------
// Bank mapper scoreboard
// Watches the request, result and configuration ports of the bank mapper,
// keeps its own copy of the mapper registers and bank state, predicts the
// mapped access for every accepted request and compares each accepted result
// in order, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  cbm_pkg::req_t                  req,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  cbm_pkg::rsp_t                  rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             pending
);

    cbm_pkg::cfg_t        map_cfg;
    cbm_pkg::bank_state_t map_banks;
    cbm_pkg::rsp_t        expected_map_q[$];
    int                   error_total;

    function automatic logic [31:0] wrap_mask(logic [cbm_pkg::LOG2_W-1:0] log2_val,
                                              int lo, int hi);
        int b;
        b = int'(log2_val);
        if (b < lo)
            b = lo;
        if (b > hi)
            b = hi;
        return (32'd1 << b) - 32'd1;
    endfunction

    function automatic void update_banks(logic [cbm_pkg::ADDR_W-1:0] a,
                                         logic [cbm_pkg::DATA_W-1:0] v);
        if (map_cfg.kind != cbm_pkg::KIND_ROM_ONLY)
        begin
            if (a < 16'h2000)
            begin
                map_banks.ram_enabled = (v[3:0] == cbm_pkg::RAM_EN_KEY);
            end
            else
            begin
                case (map_cfg.kind)
                    cbm_pkg::KIND_MBC1:
                    begin
                        if (a < 16'h4000)
                        begin
                            map_banks.rom_page = {4'd0, v[4:0]};
                            if (v[4:0] == 5'd0)
                                map_banks.rom_page = 9'd1;
                        end
                        else if (a < 16'h6000)
                            map_banks.ram_page = {6'd0, v[1:0]};
                        else
                            map_banks.banking_mode = v[0];
                    end
                    cbm_pkg::KIND_MBC3:
                    begin
                        if (a < 16'h4000)
                            map_banks.rom_page = {2'd0, v[6:0]};
                        else if (a < 16'h6000)
                            map_banks.ram_page = v;
                    end
                    default:
                    begin
                        if (a < 16'h3000)
                            map_banks.rom_page = {map_banks.rom_page[8], v};
                        else if (a < 16'h4000)
                            map_banks.rom_page = {v[0], map_banks.rom_page[7:0]};
                        else if (a < 16'h6000)
                            map_banks.ram_page = {4'd0, v[3:0]};
                    end
                endcase
            end
        end
    endfunction

    // Maps one bus access and applies any bank register write it carries.
    function automatic cbm_pkg::rsp_t map_access(cbm_pkg::req_t r);
        cbm_pkg::rsp_t o;
        logic [31:0]   bank;
        logic [31:0]   off;
        logic [31:0]   rbank;
        bit            ok;
        o        = '0;
        o.target = cbm_pkg::TGT_NONE;
        if (r.bus_addr < 16'h8000)
        begin
            if (r.op == cbm_pkg::OP_WRITE)
            begin
                update_banks(r.bus_addr, r.wdata);
            end
            else
            begin
                off = 32'(r.bus_addr);
                if (map_cfg.kind != cbm_pkg::KIND_ROM_ONLY && r.bus_addr >= 16'h4000)
                begin
                    bank = 32'(map_banks.rom_page);
                    if (map_cfg.kind == cbm_pkg::KIND_MBC1)
                    begin
                        if (bank == 32'd0)
                            bank = 32'd1;
                        if (!map_banks.banking_mode)
                            bank = bank | (32'(map_banks.ram_page) << 5);
                    end
                    else if (map_cfg.kind == cbm_pkg::KIND_MBC3)
                    begin
                        if (bank == 32'd0)
                            bank = 32'd1;
                    end
                    off = bank * 32'h4000 + (32'(r.bus_addr) - 32'h4000);
                end
                o.target    = cbm_pkg::TGT_ROM_READ;
                o.phys_addr = cbm_pkg::PHYS_W'(off & wrap_mask(map_cfg.rom_log2,
                                  int'(cbm_pkg::ROM_MIN_LOG2), cbm_pkg::ROM_ADDR_BITS_DEF));
            end
        end
        else if (r.bus_addr[15:13] == cbm_pkg::RAM_WINDOW && map_cfg.ram_present
                 && map_banks.ram_enabled)
        begin
            rbank = 32'd0;
            ok    = 1'b1;
            case (map_cfg.kind)
                cbm_pkg::KIND_MBC1:
                    rbank = map_banks.banking_mode ? 32'(map_banks.ram_page) : 32'd0;
                cbm_pkg::KIND_MBC3:
                begin
                    rbank = 32'(map_banks.ram_page);
                    ok    = (map_banks.ram_page < 8'd4);
                end
                cbm_pkg::KIND_MBC5:
                    rbank = 32'(map_banks.ram_page);
                default:
                    rbank = 32'd0;
            endcase
            if (ok)
            begin
                off         = rbank * 32'h2000 + (32'(r.bus_addr) - 32'hA000);
                o.phys_addr = cbm_pkg::PHYS_W'(off & wrap_mask(map_cfg.ram_log2,
                                  int'(cbm_pkg::RAM_MIN_LOG2), cbm_pkg::RAM_ADDR_BITS_DEF));
                if (r.op == cbm_pkg::OP_WRITE)
                begin
                    o.target    = cbm_pkg::TGT_RAM_WRITE;
                    o.ram_wdata = r.wdata;
                end
                else
                begin
                    o.target = cbm_pkg::TGT_RAM_READ;
                end
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cbm_pkg::rsp_t want;
        if (!rst_n)
        begin
            map_cfg.kind           = cbm_pkg::KIND_ROM_ONLY;
            map_cfg.rom_log2       = cbm_pkg::ROM_RESET_LOG2;
            map_cfg.ram_log2       = cbm_pkg::RAM_RESET_LOG2;
            map_cfg.ram_present    = 1'b0;
            map_banks.rom_page     = cbm_pkg::ROM_PAGE_RESET;
            map_banks.ram_page     = '0;
            map_banks.ram_enabled  = 1'b0;
            map_banks.banking_mode = 1'b0;
            expected_map_q.delete();
            error_total = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    cbm_pkg::REG_MAPPER_KIND:
                        map_cfg.kind = cbm_pkg::mapper_kind_t'(pwdata[1:0]);
                    cbm_pkg::REG_ROM_LOG2:
                        map_cfg.rom_log2 = pwdata[cbm_pkg::LOG2_W-1:0];
                    cbm_pkg::REG_RAM_LOG2:
                        map_cfg.ram_log2 = pwdata[cbm_pkg::LOG2_W-1:0];
                    default:
                        map_cfg.ram_present = pwdata[0];
                endcase
            end

            if (req_valid && req_ready)
                expected_map_q.push_back(map_access(req));

            if (rsp_valid && rsp_ready)
            begin
                if (expected_map_q.size() == 0)
                begin
                    if (error_total < 10)
                        $display("unexpected result: target %0d phys %06h wdata %02h",
                                 rsp.target, rsp.phys_addr, rsp.ram_wdata);
                    error_total++;
                end
                else
                begin
                    want = expected_map_q.pop_front();
                    if (want.target !== rsp.target || want.phys_addr !== rsp.phys_addr
                        || want.ram_wdata !== rsp.ram_wdata)
                    begin
                        if (error_total < 10)
                            $display({"mismatch: expected target %0d phys %06h wdata %02h,",
                                      " got target %0d phys %06h wdata %02h"},
                                     want.target, want.phys_addr, want.ram_wdata,
                                     rsp.target, rsp.phys_addr, rsp.ram_wdata);
                        error_total++;
                    end
                end
            end

            fail_count <= error_total;
            pending    <= expected_map_q.size();
        end
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Bank mapper testbench
// Drives bus access requests and configuration writes into the bank mapper
// core: a directed pass over the mapper kinds and their corner cases, then
// randomized phases under several register settings, with bursty requests and
// a stalling result receiver. The scoreboard beside the core does the checks.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 300000;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_ready;
    cbm_pkg::req_t                  req;
    logic                           rsp_valid;
    logic                           rsp_ready;
    cbm_pkg::rsp_t                  rsp;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cbm_pkg::CFG_ADDR_W-1:0] paddr;
    logic [cbm_pkg::CFG_DATA_W-1:0] pwdata;
    logic [cbm_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    int                             fail_count;
    int                             pending;

    int                             burst_left = 0;
    int                             stall_mode = 0;
    int                             stall_left = 0;
    int unsigned                    cycle_count = 0;

    cartridge_bank_mapper_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    bank_map_checker i_bank_map_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver switches between always ready, coin-flip stalls, rare
    // acceptance and a fixed one-in-five stall, each for a random stretch.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       rsp_ready = 1'b1;
            1:       rsp_ready = 1'($urandom_range(0, 1));
            2:       rsp_ready = ($urandom_range(0, 3) == 0);
            default: rsp_ready = (stall_left % 5 != 0);
        endcase
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_access(cbm_pkg::op_t o, logic [cbm_pkg::ADDR_W-1:0] a,
                               logic [cbm_pkg::DATA_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        req_valid    = 1'b1;
        req.op       = o;
        req.bus_addr = a;
        req.wdata    = d;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [cbm_pkg::CFG_DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Holds off new requests until every predicted result has come back.
    task automatic wait_drained();
        req_valid  = 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(negedge clk);
    endtask

    // Upper data bits carry junk, which the registers must ignore.
    task automatic set_config(cbm_pkg::mapper_kind_t k,
                              logic [cbm_pkg::LOG2_W-1:0] rom_l2,
                              logic [cbm_pkg::LOG2_W-1:0] ram_l2, logic present);
        wait_drained();
        write_reg(cbm_pkg::REG_MAPPER_KIND, ($urandom() & 32'hFFFF_FFFC) | 32'(k));
        write_reg(cbm_pkg::REG_ROM_LOG2, ($urandom() & 32'hFFFF_FFE0) | 32'(rom_l2));
        write_reg(cbm_pkg::REG_RAM_LOG2, ($urandom() & 32'hFFFF_FFE0) | 32'(ram_l2));
        write_reg(cbm_pkg::REG_RAM_PRESENT, ($urandom() & 32'hFFFF_FFFE) | 32'(present));
    endtask

    function automatic logic [cbm_pkg::LOG2_W-1:0] pick_log2(int lo, int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return cbm_pkg::LOG2_W'(lo);
        else if (r == 1)
            return cbm_pkg::LOG2_W'(hi);
        else if (r == 2)
            return cbm_pkg::LOG2_W'($urandom_range(0, 31));
        return cbm_pkg::LOG2_W'($urandom_range(lo, hi));
    endfunction

    // Mostly bank register writes, ROM reads and RAM window accesses, with
    // enable keys and small RAM banks favored so that RAM traffic gets through.
    task automatic random_access();
        int                         sel;
        logic [cbm_pkg::ADDR_W-1:0] a;
        logic [cbm_pkg::DATA_W-1:0] d;
        cbm_pkg::op_t               o;
        sel = $urandom_range(0, 99);
        a   = cbm_pkg::ADDR_W'($urandom());
        d   = cbm_pkg::DATA_W'($urandom());
        o   = cbm_pkg::op_t'($urandom_range(0, 1));
        if (sel < 25)
        begin
            o     = cbm_pkg::OP_WRITE;
            a[15] = 1'b0;
            if (a[14:13] == cbm_pkg::WIN_RAM_EN && $urandom_range(0, 1) == 1)
                d[3:0] = cbm_pkg::RAM_EN_KEY;
            else if (a[14:13] == cbm_pkg::WIN_RAM_PAGE && $urandom_range(0, 2) != 0)
                d = cbm_pkg::DATA_W'($urandom_range(0, 3));
        end
        else if (sel < 55)
        begin
            o     = cbm_pkg::OP_READ;
            a[15] = 1'b0;
        end
        else if (sel < 90)
        begin
            a[15:13] = cbm_pkg::RAM_WINDOW;
        end
        send_access(o, a, d);
    endtask

    initial
    begin : stimulus
        cbm_pkg::mapper_kind_t      k;
        logic [cbm_pkg::LOG2_W-1:0] rom_l2;
        logic [cbm_pkg::LOG2_W-1:0] ram_l2;
        logic                       present;
        int                         p;
        int                         i;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Power-on settings: ROM only, no external RAM.
        send_access(cbm_pkg::OP_READ, 16'h0000, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'h7FFF, 8'hFF);
        send_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h05);
        send_access(cbm_pkg::OP_WRITE, 16'hA000, 8'hFF);
        send_access(cbm_pkg::OP_READ, 16'hFFFF, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF);

        // MBC1: disabled RAM, bank zero promoted to one, upper bits in mode 0.
        set_config(cbm_pkg::KIND_MBC1, 5'd23, 5'd17, 1'b1);
        send_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);
        send_access(cbm_pkg::OP_WRITE, 16'h3FFF, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h03);
        send_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h6000, 8'h01);
        send_access(cbm_pkg::OP_WRITE, 16'hBFFF, 8'hA5);
        send_access(cbm_pkg::OP_READ, 16'hC000, 8'h00);

        // MBC3: RAM bank of four or more blocks the RAM window.
        set_config(cbm_pkg::KIND_MBC3, 5'd22, 5'd17, 1'b1);
        send_access(cbm_pkg::OP_WRITE, 16'h5FFF, 8'h04);
        send_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h80);
        send_access(cbm_pkg::OP_READ, 16'h4001, 8'h00);

        // MBC5: ninth ROM bank bit, and the RAM bank carried over from MBC3.
        set_config(cbm_pkg::KIND_MBC5, 5'd23, 5'd17, 1'b1);
        send_access(cbm_pkg::OP_WRITE, 16'h3000, 8'h01);
        send_access(cbm_pkg::OP_WRITE, 16'h2FFF, 8'hFF);
        send_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h1FFF, 8'h0A);
        send_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);

        // ROM only with RAM still enabled: offset wraps to the smallest RAM,
        // and an out-of-range ROM size clamps to the smallest ROM.
        set_config(cbm_pkg::KIND_ROM_ONLY, 5'd0, 5'd9, 1'b1);
        send_access(cbm_pkg::OP_READ, 16'hBFFF, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);

        for (p = 0; p < 10; p++)
        begin
            k       = (p < 4) ? cbm_pkg::mapper_kind_t'(2'(p))
                              : cbm_pkg::mapper_kind_t'($urandom_range(0, 3));
            rom_l2  = pick_log2(15, 23);
            ram_l2  = pick_log2(9, 17);
            present = ($urandom_range(0, 7) != 0);
            case (p)
                0:
                begin
                    rom_l2 = 5'd15;
                    ram_l2 = 5'd9;
                end
                1:
                begin
                    rom_l2 = 5'd23;
                    ram_l2 = 5'd17;
                end
                2:
                begin
                    rom_l2 = 5'd0;
                    ram_l2 = 5'd0;
                end
                3:
                begin
                    rom_l2 = 5'd31;
                    ram_l2 = 5'd31;
                end
                4:       present = 1'b0;
                default: ;
            endcase
            set_config(k, rom_l2, ram_l2, present);
            for (i = 0; i < 165; i++)
                random_access();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
